>>> rtl/core/ita2_pkg.sv
// ----------------------------------------------------------------------------
// ITA2 shift encoder package
// Shared types, shift codes and the two ITA2 character tables.
// ----------------------------------------------------------------------------
package ita2_pkg;

    // Shift codes
    localparam logic [4:0] CODE_FIGS = 5'd27;
    localparam logic [4:0] CODE_LTRS = 5'd31;

    // One result transaction
    typedef struct packed {
        logic [4:0] code;
        logic       code_valid;
        logic       miss;
        logic       last;
    } result_t;

    // Outcome of a table search
    typedef struct packed {
        logic       found;
        logic [4:0] code;
    } lookup_t;

    // Everything the encoder decides for one character
    typedef struct packed {
        result_t first;
        result_t second;
        logic    two;
        logic    shift_next;
    } enc_t;

    // Letters table: lowest code that holds the character.
    function automatic lookup_t find_letters(input logic [7:0] ch);
        lookup_t r;
        r.found = 1'b1;
        unique case (ch)
            8'h00: r.code = 5'd0;
            8'h45: r.code = 5'd1;   // E
            8'h0A: r.code = 5'd2;   // line feed
            8'h41: r.code = 5'd3;   // A
            8'h20: r.code = 5'd4;   // space
            8'h53: r.code = 5'd5;   // S
            8'h49: r.code = 5'd6;   // I
            8'h55: r.code = 5'd7;   // U
            8'h0D: r.code = 5'd8;   // carriage return
            8'h44: r.code = 5'd9;   // D
            8'h52: r.code = 5'd10;  // R
            8'h4A: r.code = 5'd11;  // J
            8'h4E: r.code = 5'd12;  // N
            8'h46: r.code = 5'd13;  // F
            8'h43: r.code = 5'd14;  // C
            8'h4B: r.code = 5'd15;  // K
            8'h54: r.code = 5'd16;  // T
            8'h5A: r.code = 5'd17;  // Z
            8'h4C: r.code = 5'd18;  // L
            8'h57: r.code = 5'd19;  // W
            8'h48: r.code = 5'd20;  // H
            8'h59: r.code = 5'd21;  // Y
            8'h50: r.code = 5'd22;  // P
            8'h51: r.code = 5'd23;  // Q
            8'h4F: r.code = 5'd24;  // O
            8'h42: r.code = 5'd25;  // B
            8'h47: r.code = 5'd26;  // G
            8'h4D: r.code = 5'd28;  // M
            8'h58: r.code = 5'd29;  // X
            8'h56: r.code = 5'd30;  // V
            default:
            begin
                r.found = 1'b0;
                r.code  = 5'd0;
            end
        endcase
        return r;
    endfunction

    // Figures table: lowest code that holds the character.
    function automatic lookup_t find_figures(input logic [7:0] ch);
        lookup_t r;
        r.found = 1'b1;
        unique case (ch)
            8'h00: r.code = 5'd0;
            8'h33: r.code = 5'd1;   // 3
            8'h0A: r.code = 5'd2;   // line feed
            8'h2D: r.code = 5'd3;   // minus
            8'h20: r.code = 5'd4;   // space
            8'h27: r.code = 5'd5;   // apostrophe
            8'h38: r.code = 5'd6;   // 8
            8'h37: r.code = 5'd7;   // 7
            8'h0D: r.code = 5'd8;   // carriage return
            8'h44: r.code = 5'd9;   // D
            8'h34: r.code = 5'd10;  // 4
            8'h21: r.code = 5'd11;  // exclamation mark, first of two places
            8'h2C: r.code = 5'd12;  // comma
            8'h3A: r.code = 5'd14;  // colon
            8'h28: r.code = 5'd15;  // open bracket
            8'h35: r.code = 5'd16;  // 5
            8'h22: r.code = 5'd17;  // double quote
            8'h29: r.code = 5'd18;  // close bracket
            8'h32: r.code = 5'd19;  // 2
            8'h23: r.code = 5'd20;  // hash
            8'h36: r.code = 5'd21;  // 6
            8'h30: r.code = 5'd22;  // 0
            8'h31: r.code = 5'd23;  // 1
            8'h39: r.code = 5'd24;  // 9
            8'h3F: r.code = 5'd25;  // question mark
            8'h26: r.code = 5'd26;  // ampersand
            8'h2E: r.code = 5'd28;  // full stop
            8'h2F: r.code = 5'd29;  // slash
            8'h3D: r.code = 5'd30;  // equals
            default:
            begin
                r.found = 1'b0;
                r.code  = 5'd0;
            end
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/ita2_if.sv
// ----------------------------------------------------------------------------
// ITA2 channel interfaces
// Valid/ready channels for input characters and output code results.
// ----------------------------------------------------------------------------

// Character channel
interface ita2_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

// Code result channel
interface ita2_code_if;
    logic       valid;
    logic       ready;
    logic [4:0] code;
    logic       code_valid;
    logic       miss;
    logic       last;

    modport source (output valid, output code, output code_valid, output miss,
                    output last, input ready);
    modport sink   (input valid, input code, input code_valid, input miss,
                    input last, output ready);
endinterface

>>> rtl/core/ita2_encode.sv
// ----------------------------------------------------------------------------
// ITA2 character encoder
// Folds case, searches both tables and decides the one or two results.
// ----------------------------------------------------------------------------
module ita2_encode (
    input  logic [7:0]    char_in,
    input  logic          shift_figures,
    input  logic          auto_shift,
    output ita2_pkg::enc_t enc
);

    logic [7:0]        ch;
    ita2_pkg::lookup_t in_ltrs;
    ita2_pkg::lookup_t in_figs;
    ita2_pkg::lookup_t in_active;
    ita2_pkg::lookup_t in_other;
    ita2_pkg::lookup_t in_needed;
    logic              needed;

    // Fold lower-case letters to upper case.
    always_comb
    begin
        if (char_in >= 8'h61 && char_in <= 8'h7A)
            ch = char_in - 8'h20;
        else
            ch = char_in;
    end

    // Table searches.
    always_comb
    begin
        in_ltrs   = ita2_pkg::find_letters(ch);
        in_figs   = ita2_pkg::find_figures(ch);
        in_active = shift_figures ? in_figs : in_ltrs;
        in_other  = shift_figures ? in_ltrs : in_figs;
    end

    // A character present in only one table picks that shift when enabled.
    always_comb
    begin
        needed = shift_figures;
        if (auto_shift)
        begin
            if (in_ltrs.found && !in_figs.found)
                needed = 1'b0;
            else if (in_figs.found && !in_ltrs.found)
                needed = 1'b1;
        end
        in_needed = needed ? in_figs : in_ltrs;
    end

    // Build the results and the new shift state.
    always_comb
    begin
        enc.first      = '0;
        enc.second     = '0;
        enc.two        = 1'b0;
        enc.shift_next = shift_figures;
        if (needed != shift_figures)
        begin
            // Chosen shift always holds the character.
            enc.first.code        = needed ? ita2_pkg::CODE_FIGS : ita2_pkg::CODE_LTRS;
            enc.first.code_valid  = 1'b1;
            enc.second.code       = in_needed.code;
            enc.second.code_valid = 1'b1;
            enc.second.last       = 1'b1;
            enc.two               = 1'b1;
            enc.shift_next        = needed;
        end
        else if (in_active.found)
        begin
            enc.first.code       = in_active.code;
            enc.first.code_valid = 1'b1;
            enc.first.last       = 1'b1;
        end
        else if (in_other.found)
        begin
            // Missing from the active table: switch over and flag it.
            enc.first.code        = shift_figures ? ita2_pkg::CODE_LTRS
                                                  : ita2_pkg::CODE_FIGS;
            enc.first.code_valid  = 1'b1;
            enc.first.miss        = 1'b1;
            enc.second.code       = in_other.code;
            enc.second.code_valid = 1'b1;
            enc.second.miss       = 1'b1;
            enc.second.last       = 1'b1;
            enc.two               = 1'b1;
            enc.shift_next        = ~shift_figures;
        end
        else
        begin
            // In neither table: a single empty result.
            enc.first.miss = 1'b1;
            enc.first.last = 1'b1;
        end
    end

endmodule

>>> rtl/core/ita2_emit.sv
// ----------------------------------------------------------------------------
// ITA2 result emitter
// Holds up to two results of one character and presents them in order.
// ----------------------------------------------------------------------------
module ita2_emit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  ita2_pkg::enc_t       enc,
    output logic                 free,
    ita2_code_if.source          code_ch
);

    logic [1:0]        cnt_reg;
    logic [1:0]        cnt_next;
    ita2_pkg::result_t head_reg;
    ita2_pkg::result_t head_next;
    ita2_pkg::result_t tail_reg;
    ita2_pkg::result_t tail_next;
    logic              pop;

    assign code_ch.valid      = (cnt_reg != 2'd0);
    assign code_ch.code       = head_reg.code;
    assign code_ch.code_valid = head_reg.code_valid;
    assign code_ch.miss       = head_reg.miss;
    assign code_ch.last       = head_reg.last;

    assign pop  = code_ch.valid && code_ch.ready;
    assign free = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && code_ch.ready);

    // Advance on a taken transaction, refill when a new pair arrives.
    always_comb
    begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        if (pop)
        begin
            if (cnt_reg == 2'd2)
            begin
                head_next = tail_reg;
                cnt_next  = 2'd1;
            end
            else
                cnt_next = 2'd0;
        end
        if (load)
        begin
            head_next = enc.first;
            tail_next = enc.second;
            cnt_next  = enc.two ? 2'd2 : 2'd1;
        end
    end

    // Occupancy count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

>>> rtl/core/ita2_shift_encoder.sv
// ----------------------------------------------------------------------------
// ITA2 shift encoder
// Turns 8-bit characters into ITA2 5-bit codes with letters/figures shifts.
// ----------------------------------------------------------------------------
// Usage:
// Characters arrive on char_ch and 5-bit results leave on code_ch, both
// valid/ready channels. Each character gives one result, or two when a
// FIGS or LTRS shift code must come first; last marks the final one.
// cfg_wr_en/cfg_wr_data write the auto-shift enable; write it only while
// the block is idle.
// A character is held in an input register until the result stage can
// take it, then encoded and loaded into the result stage, which offers
// the first result. The result stage sends one transaction per cycle
// while the receiver is ready; this one-result-per-cycle output sets the
// throughput.
// A new character is accepted while results are still waiting.
// Reset empties both stages, selects the letters shift and clears the
// auto-shift enable. When the receiver stalls the current result holds
// and the input channel backs up once both stages are full.
// ----------------------------------------------------------------------------
module ita2_shift_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    ita2_char_if.sink   char_ch,
    ita2_code_if.source code_ch
);

    logic           auto_shift_reg;
    logic           shift_reg;
    logic           shift_next;
    logic           in_valid_reg;
    logic           in_valid_next;
    logic [7:0]     char_reg;
    logic           take;
    logic           emit_free;
    ita2_pkg::enc_t enc;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            auto_shift_reg <= 1'b0;
        else if (cfg_wr_en)
            auto_shift_reg <= cfg_wr_data;
    end

    // Input stage hands over when the emitter can take a new pair.
    assign take          = in_valid_reg && emit_free;
    assign char_ch.ready = !in_valid_reg || take;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (char_ch.valid && char_ch.ready)
            in_valid_next = 1'b1;
        else if (take)
            in_valid_next = 1'b0;
        shift_next = take ? enc.shift_next : shift_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            shift_reg    <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            shift_reg    <= shift_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_ch.valid && char_ch.ready)
            char_reg <= char_ch.char_in;
    end

    // Encoder and result stage.
    ita2_encode u_encode (
        .char_in       (char_reg),
        .shift_figures (shift_reg),
        .auto_shift    (auto_shift_reg),
        .enc           (enc)
    );

    ita2_emit u_emit (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (take),
        .enc     (enc),
        .free    (emit_free),
        .code_ch (code_ch)
    );

    // Checks.
    a_empty_is_final_miss: assert property (@(posedge clk) disable iff (!rst_n)
        code_ch.valid && !code_ch.code_valid |-> code_ch.last && code_ch.miss)
        else $error("empty result without last and miss");

    a_first_is_shift: assert property (@(posedge clk) disable iff (!rst_n)
        code_ch.valid && !code_ch.last |->
            code_ch.code == ita2_pkg::CODE_FIGS || code_ch.code == ita2_pkg::CODE_LTRS)
        else $error("non-final result is not a shift code");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        code_ch.valid && code_ch.ready && !code_ch.last |=> code_ch.valid)
        else $error("second result of a pair missing");

    a_shift_only_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(shift_reg))
        else $error("shift state changed without a character");

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// ITA2 shift encoder testbench
// Sends characters through the encoder in both auto-shift settings and checks
// every code transaction against an in-bench model of the shift logic and
// the two ITA2 tables. Both channels stall at random, with one phase where
// neither side idles and one where the sender waits for the block to drain.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 6;
    localparam int IDLE_PERCENT = 31;

    // ITA2 tables, code 0 first; codes 27 and 31 are the shift codes
    localparam logic [0:31][7:0] LETTERS_MAP = {
        8'h00, 8'h45, 8'h0A, 8'h41, 8'h20, 8'h53, 8'h49, 8'h55,
        8'h0D, 8'h44, 8'h52, 8'h4A, 8'h4E, 8'h46, 8'h43, 8'h4B,
        8'h54, 8'h5A, 8'h4C, 8'h57, 8'h48, 8'h59, 8'h50, 8'h51,
        8'h4F, 8'h42, 8'h47, 8'h00, 8'h4D, 8'h58, 8'h56, 8'h00
    };
    localparam logic [0:31][7:0] FIGURES_MAP = {
        8'h00, 8'h33, 8'h0A, 8'h2D, 8'h20, 8'h27, 8'h38, 8'h37,
        8'h0D, 8'h44, 8'h34, 8'h21, 8'h2C, 8'h21, 8'h3A, 8'h28,
        8'h35, 8'h22, 8'h29, 8'h32, 8'h23, 8'h36, 8'h30, 8'h31,
        8'h39, 8'h3F, 8'h26, 8'h00, 8'h2E, 8'h2F, 8'h3D, 8'h00
    };

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic       cfg_wr_data;

    // Values driven onto the channels, known from time zero
    logic       char_valid = 1'b0;
    logic [7:0] char_data = 8'h00;
    logic       code_ready = 1'b0;

    // Model state and bench bookkeeping
    logic                shift_figures;
    logic                auto_shift_model;
    logic                steady;
    logic [7:0]          chars_to_send [$];
    ita2_pkg::result_t   codes_due [$];
    int                  mismatches;
    int                  cycles;

    ita2_char_if char_ch ();
    ita2_code_if code_ch ();

    assign char_ch.valid   = char_valid;
    assign char_ch.char_in = char_data;
    assign code_ch.ready   = code_ready;

    ita2_shift_encoder u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .char_ch     (char_ch),
        .code_ch     (code_ch)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Lowest code holding the character in one table, or -1 when absent.
    function automatic int code_of(input logic [7:0] ch, input logic figs);
        for (int i = 0; i < 32; i++)
        begin
            if (i != 27 && i != 31)
            begin
                if ((figs ? FIGURES_MAP[i] : LETTERS_MAP[i]) == ch)
                    return i;
            end
        end
        return -1;
    endfunction

    function automatic ita2_pkg::result_t make_result(input logic [4:0] code,
                                                      input logic code_valid,
                                                      input logic miss,
                                                      input logic last);
        ita2_pkg::result_t r;
        r.code       = code;
        r.code_valid = code_valid;
        r.miss       = miss;
        r.last       = last;
        return r;
    endfunction

    // Works out the code transactions one character causes and updates the shift.
    task automatic encode_char(input logic [7:0] raw);
        logic [7:0] ch;
        logic       want;
        int         in_ltrs;
        int         in_figs;
        int         hit;
        ch = raw;
        if (raw >= 8'h61 && raw <= 8'h7A)
            ch = raw - 8'h20;
        in_ltrs = code_of(ch, 1'b0);
        in_figs = code_of(ch, 1'b1);
        want = shift_figures;
        if (auto_shift_model)
        begin
            if (in_ltrs >= 0 && in_figs < 0)
                want = 1'b0;
            else if (in_figs >= 0 && in_ltrs < 0)
                want = 1'b1;
        end
        if (want != shift_figures)
        begin
            codes_due.push_back(make_result(want ? ita2_pkg::CODE_FIGS
                                                 : ita2_pkg::CODE_LTRS,
                                            1'b1, 1'b0, 1'b0));
            shift_figures = want;
        end
        hit = shift_figures ? in_figs : in_ltrs;
        if (hit >= 0)
        begin
            codes_due.push_back(make_result(hit[4:0], 1'b1, 1'b0, 1'b1));
        end
        else
        begin
            // Missing from the active table: try the other one, flagged as a miss
            hit = shift_figures ? in_ltrs : in_figs;
            if (hit >= 0)
            begin
                codes_due.push_back(make_result(shift_figures ? ita2_pkg::CODE_LTRS
                                                              : ita2_pkg::CODE_FIGS,
                                                1'b1, 1'b1, 1'b0));
                codes_due.push_back(make_result(hit[4:0], 1'b1, 1'b1, 1'b1));
                shift_figures = ~shift_figures;
            end
            else
            begin
                codes_due.push_back(make_result(5'd0, 1'b0, 1'b1, 1'b1));
            end
        end
    endtask

    // Random character, weighted towards the table contents.
    function automatic logic [7:0] pick_char();
        int roll;
        int idx;
        roll = $urandom_range(0, 99);
        if (roll < 35)
        begin
            return 8'h41 + 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? 8'h20 : 8'h00);
        end
        else if (roll < 75)
        begin
            idx = $urandom_range(0, 29);
            if (idx >= 27)
                idx = idx + 1;
            return FIGURES_MAP[idx];
        end
        else if (roll < 82)
        begin
            idx = $urandom_range(0, 4);
            return (idx == 0) ? 8'h00 : (idx == 1) ? 8'h20 : (idx == 2) ? 8'h0A :
                   (idx == 3) ? 8'h0D : 8'h44;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Character sender: records each accepted transaction in the model
    always @(posedge clk)
    begin
        logic       send;
        logic [7:0] next_char;
        if (rst_n)
        begin
            send = 1'b0;
            next_char = char_data;
            if (char_valid && char_ch.ready)
                encode_char(char_data);
            if (!char_valid || char_ch.ready)
            begin
                if (chars_to_send.size() != 0 &&
                    (steady || $urandom_range(0, 99) >= IDLE_PERCENT))
                begin
                    send = 1'b1;
                    next_char = chars_to_send.pop_front();
                end
                char_valid <= send;
                char_data <= next_char;
            end
        end
    end

    // Code receiver: compares each transaction with the oldest expected one
    always @(posedge clk)
    begin
        ita2_pkg::result_t seen;
        ita2_pkg::result_t want;
        if (rst_n)
        begin
            if (code_ch.valid && code_ready)
            begin
                seen = make_result(code_ch.code, code_ch.code_valid, code_ch.miss,
                                   code_ch.last);
                if (codes_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected code transaction: %s",
                                 $sformatf("code=%0d valid=%0b miss=%0b last=%0b",
                                           seen.code, seen.code_valid, seen.miss,
                                           seen.last));
                end
                else
                begin
                    want = codes_due.pop_front();
                    if (seen !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected code=%0d valid=%0b miss=%0b last=%0b, %s",
                                     want.code, want.code_valid, want.miss, want.last,
                                     $sformatf("got code=%0d valid=%0b miss=%0b last=%0b",
                                               seen.code, seen.code_valid, seen.miss,
                                               seen.last));
                    end
                end
            end
            code_ready <= steady || $urandom_range(0, 99) >= IDLE_PERCENT;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Waits until every character has been sent and every code has arrived.
    task automatic wait_drained();
        while (chars_to_send.size() != 0 || char_valid || codes_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_auto_shift(input logic value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        auto_shift_model = value;
    endtask

    task automatic queue_random(input int count, input logic hold);
        for (int n = 0; n < count; n++)
        begin
            chars_to_send.push_back(pick_char());
            // Now and then the sender stops until the block has emptied
            if (hold && n % 40 == 39)
                wait_drained();
        end
        wait_drained();
    endtask

    // Stimulus
    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 1'b0;
        shift_figures = 1'b0;
        auto_shift_model = 1'b0;
        steady = 1'b0;
        mismatches = 0;
        cycles = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Manual shift after reset: blank, folding, misses in both directions
        chars_to_send = '{8'h00, 8'h61, 8'h7A, 8'h41, 8'h33, 8'h44, 8'h21, 8'h2E,
                          8'h45, 8'h21, 8'hFF, 8'h80, 8'h7B, 8'h60, 8'h7F, 8'h20,
                          8'h0A, 8'h0D};
        wait_drained();

        // Auto-shift: unambiguous characters choose, shared ones keep the shift
        write_auto_shift(1'b1);
        chars_to_send = '{8'h35, 8'h44, 8'h71, 8'h21, 8'h20, 8'h3D, 8'hE9, 8'h40,
                          8'h00, 8'h5A};
        wait_drained();

        // Random phases across both settings
        write_auto_shift(1'b0);
        queue_random(400, 1'b0);
        write_auto_shift(1'b1);
        steady = 1'b1;
        queue_random(400, 1'b0);
        steady = 1'b0;
        write_auto_shift(1'b0);
        queue_random(400, 1'b1);
        write_auto_shift(1'b1);
        queue_random(400, 1'b0);

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
